FILE: rtl/core/assert_macros.svh
// Assertion helpers used by the checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, held off while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// Two signals that are never high together on a valid word.
`define ASSERT_NEVER_BOTH(label, clk, rst_n, vld, a, b) \
	`ASSERT_CLK(label, clk, rst_n, !(vld && a && b))

`endif

FILE: rtl/core/kpt_pkg.sv
package kpt_pkg;

	// Command codes carried by the event word
	typedef enum logic [2:0] {
		CMD_ACTIVITY = 3'd0,
		CMD_CHECK    = 3'd1,
		CMD_SEND     = 3'd2,
		CMD_TIMEOUT  = 3'd3,
		CMD_RESET    = 3'd4
	} cmd_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_IDLE_THRESHOLD = 2'd0,
		REG_PROBE_INTERVAL = 2'd1,
		REG_PROBE_LIMIT    = 2'd2,
		REG_ENABLE         = 2'd3
	} reg_idx_t;

	localparam int unsigned TIME_W  = 32;
	localparam int unsigned COUNT_W = 8;
	localparam int unsigned CFG_W   = 32;

	// Values after reset
	localparam logic [TIME_W-1:0]  IDLE_THRESHOLD_RST = 32'd7200;
	localparam logic [TIME_W-1:0]  PROBE_INTERVAL_RST = 32'd75;
	localparam logic [COUNT_W-1:0] PROBE_LIMIT_RST    = 8'd9;
	localparam logic               ENABLE_RST         = 1'b1;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

endpackage

FILE: rtl/core/kpt_event_if.sv
interface kpt_event_if;
	import kpt_pkg::*;

	logic              valid;
	logic              ready;
	logic [2:0]        command;
	logic [TIME_W-1:0] now_seconds;

	modport source (output valid, command, now_seconds, input ready);
	modport sink (input valid, command, now_seconds, output ready);
endinterface

FILE: rtl/core/kpt_status_if.sv
interface kpt_status_if;
	import kpt_pkg::*;

	logic               valid;
	logic               ready;
	logic               probe_due;
	logic               send_accepted;
	logic [COUNT_W-1:0] probes_sent_count;
	logic [TIME_W-1:0]  last_active_seconds;
	logic               timed_out;
	logic               probe_sent_flag;

	modport source (output valid, probe_due, send_accepted, probes_sent_count,
		last_active_seconds, timed_out, probe_sent_flag, input ready);
	modport sink (input valid, probe_due, send_accepted, probes_sent_count,
		last_active_seconds, timed_out, probe_sent_flag, output ready);
endinterface

FILE: rtl/core/keepalive_probe_timer_unit.sv
// Keepalive timer for one connection.
// event_ch (sink): one word per event, a command and the current time in
//   seconds (wrapping 32-bit counter). Commands: activity, check, send,
//   force timeout and clear.
// status_ch (source): exactly one word per event, in order: probe_due,
//   send_accepted, the probe count, the last activity time and the flags
//   as they stand after that event.
// cfg_*: register write port (idle threshold, probe interval, probe limit,
//   enable), to be written only while no event is outstanding (not enforced).
// Latency: the status word is valid the cycle after the event is taken.
// Throughput: one event per cycle while no status word is stalled; the state
//   update and the status word are computed in one pass (a 32-bit subtract,
//   a 32-bit add and two 32-bit compares) and land together at the accept edge.
// Stall: the status register holds its word while status_ch.ready is low,
//   and a new event is taken only if that word leaves in the same cycle.
// Reset: arst_n clears the connection state and loads the register
//   defaults (7200 s idle, 75 s interval, 9 probes, enabled).
module keepalive_probe_timer_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [kpt_pkg::CFG_W-1:0]  cfg_wdata,
	kpt_event_if.sink                  event_ch,
	kpt_status_if.source               status_ch
);
	import kpt_pkg::*;

	// Configuration registers
	logic [TIME_W-1:0]  idle_threshold_q;
	logic [TIME_W-1:0]  probe_interval_q;
	logic [COUNT_W-1:0] probe_limit_q;
	logic               enable_q;

	// Connection state
	logic [TIME_W-1:0]  last_active_q;
	logic [COUNT_W-1:0] probe_counter_q;
	logic [TIME_W-1:0]  next_probe_at_q;
	logic               sent_flag_q;
	logic               timeout_flag_q;

	// Next state and this word's pulses
	logic [TIME_W-1:0]  last_active_d;
	logic [COUNT_W-1:0] probe_counter_d;
	logic [TIME_W-1:0]  next_probe_at_d;
	logic               sent_flag_d;
	logic               timeout_flag_d;
	logic               due_d;
	logic               accepted_d;

	logic [TIME_W-1:0]  idle_elapsed;
	logic [COUNT_W-1:0] count_inc;
	logic               accept;
	logic               out_valid_q;

	assign accept         = event_ch.valid && event_ch.ready;
	assign event_ch.ready = !out_valid_q || status_ch.ready;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_threshold_q <= IDLE_THRESHOLD_RST;
			probe_interval_q <= PROBE_INTERVAL_RST;
			probe_limit_q    <= PROBE_LIMIT_RST;
			enable_q         <= ENABLE_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_IDLE_THRESHOLD: idle_threshold_q <= cfg_wdata[TIME_W-1:0];
				REG_PROBE_INTERVAL: probe_interval_q <= cfg_wdata[TIME_W-1:0];
				REG_PROBE_LIMIT:    probe_limit_q    <= cfg_wdata[COUNT_W-1:0];
				REG_ENABLE:         enable_q         <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign idle_elapsed = event_ch.now_seconds - last_active_q;
	assign count_inc = (probe_counter_q == COUNT_MAX) ? COUNT_MAX
		: probe_counter_q + COUNT_W'(1);

	// Command decode
	always_comb begin
		last_active_d   = last_active_q;
		probe_counter_d = probe_counter_q;
		next_probe_at_d = next_probe_at_q;
		sent_flag_d     = sent_flag_q;
		timeout_flag_d  = timeout_flag_q;
		due_d           = 1'b0;
		accepted_d      = 1'b0;
		unique case (cmd_t'(event_ch.command))
			CMD_ACTIVITY: begin
				last_active_d   = event_ch.now_seconds;
				probe_counter_d = '0;
				next_probe_at_d = '0;
				sent_flag_d     = 1'b0;
				timeout_flag_d  = 1'b0;
			end
			CMD_CHECK: begin
				due_d = enable_q && (idle_elapsed >= idle_threshold_q)
					&& (event_ch.now_seconds >= next_probe_at_q)
					&& (probe_counter_q < probe_limit_q);
			end
			CMD_SEND: begin
				if (enable_q) begin
					probe_counter_d = count_inc;
					next_probe_at_d = event_ch.now_seconds + probe_interval_q;
					sent_flag_d     = 1'b1;
					accepted_d      = 1'b1;
					if (count_inc >= probe_limit_q) begin
						timeout_flag_d = 1'b1;
					end
				end
			end
			CMD_TIMEOUT: begin
				timeout_flag_d  = 1'b1;
				probe_counter_d = probe_limit_q;
				sent_flag_d     = 1'b1;
			end
			CMD_RESET: begin
				last_active_d   = '0;
				probe_counter_d = '0;
				next_probe_at_d = '0;
				sent_flag_d     = 1'b0;
				timeout_flag_d  = 1'b0;
			end
			default: ;
		endcase
	end

	// State update on accepted words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_active_q   <= '0;
			probe_counter_q <= '0;
			next_probe_at_q <= '0;
			sent_flag_q     <= 1'b0;
			timeout_flag_q  <= 1'b0;
		end else if (accept) begin
			last_active_q   <= last_active_d;
			probe_counter_q <= probe_counter_d;
			next_probe_at_q <= next_probe_at_d;
			sent_flag_q     <= sent_flag_d;
			timeout_flag_q  <= timeout_flag_d;
		end
	end

	// Status register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (event_ch.ready) begin
			out_valid_q <= event_ch.valid;
		end
	end

	// Status register payload
	always_ff @(posedge clk) begin
		if (accept) begin
			status_ch.probe_due           <= due_d;
			status_ch.send_accepted       <= accepted_d;
			status_ch.probes_sent_count   <= probe_counter_d;
			status_ch.last_active_seconds <= last_active_d;
			status_ch.timed_out           <= timeout_flag_d;
			status_ch.probe_sent_flag     <= sent_flag_d;
		end
	end

	assign status_ch.valid = out_valid_q;

endmodule

FILE: rtl/core/kpt_checker.sv
`include "assert_macros.svh"

module kpt_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic probe_due,
	input logic send_accepted,
	input logic timed_out,
	input logic probe_sent_flag
);

	// A stalled status word stays offered
	`ASSERT_CLK(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid)

	// Every accepted event yields a status word on the next cycle
	`ASSERT_CLK(a_one_result, clk, arst_n, in_valid && in_ready |=> out_valid)

	// Input backpressure only comes from a stalled status word
	`ASSERT_CLK(a_ready_src, clk, arst_n, !in_ready |-> out_valid && !out_ready)

	// A check and a send can never be reported on the same word
	`ASSERT_NEVER_BOTH(a_due_vs_send, clk, arst_n, out_valid, probe_due, send_accepted)

	// Timeout always comes with the sent flag set
	`ASSERT_CLK(a_timeout_sent, clk, arst_n, out_valid && timed_out |-> probe_sent_flag)

endmodule

bind keepalive_probe_timer_unit kpt_checker u_kpt_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (event_ch.valid),
	.in_ready        (event_ch.ready),
	.out_valid       (status_ch.valid),
	.out_ready       (status_ch.ready),
	.probe_due       (status_ch.probe_due),
	.send_accepted   (status_ch.send_accepted),
	.timed_out       (status_ch.timed_out),
	.probe_sent_flag (status_ch.probe_sent_flag)
);
